@@ design/cmt_pkg.sv @@
// Shared types, constants and helper functions for the combo hold mode toggle block.
// Used by cmt_cfg, cmt_core, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cmt_pkg;

  localparam int unsigned BTN_W  = 16;
  localparam int unsigned DT_W   = 10;
  localparam int unsigned HOLD_W = 16;
  localparam int unsigned TIME_W = 17;
  localparam int unsigned UI_W   = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Pad button bit positions.
  localparam int unsigned BTN_UP     = 0;
  localparam int unsigned BTN_DOWN   = 1;
  localparam int unsigned BTN_LEFT   = 2;
  localparam int unsigned BTN_RIGHT  = 3;
  localparam int unsigned BTN_CROSS  = 4;
  localparam int unsigned BTN_CIRCLE = 5;
  localparam int unsigned BTN_L1     = 6;
  localparam int unsigned BTN_R1     = 7;

  // UI button bit positions.
  localparam int unsigned UI_UP     = 0;
  localparam int unsigned UI_DOWN   = 1;
  localparam int unsigned UI_LEFT   = 2;
  localparam int unsigned UI_RIGHT  = 3;
  localparam int unsigned UI_CIRCLE = 4;

  localparam logic [BTN_W-1:0]  COMBO_MASK_RST = 16'h00C0;
  localparam logic [HOLD_W-1:0] HOLD_TIME_RST  = 16'd1000;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_EXIT  = 2'd2
  } ev_t;

  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_FORCE = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_COMBO_MASK = 1'b0,
    CFG_HOLD_TIME  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [BTN_W-1:0]  combo_mask;
    logic [HOLD_W-1:0] hold_time_ms;
  } cfg_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [BTN_W-1:0] buttons;
    logic [DT_W-1:0]  elapsed_ms;
    logic             set_on;
  } item_t;

  typedef struct packed {
    ev_t             ev;
    logic            mode_active;
    logic            muted;
    logic [UI_W-1:0] ui_buttons;
    logic            changed;
  } result_t;

  typedef struct packed {
    logic              mode_on;
    logic              combo_seen;
    logic [TIME_W-1:0] combo_time;
    logic              combo_fired;
    logic              cross_pressed;
    logic              cross_counting;
    logic [TIME_W-1:0] cross_time;
    logic              wait_cross_release;
    logic [UI_W-1:0]   ui_latch;
  } state_t;

  // Saturating timer add.
  function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] t,
                                                input logic [DT_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W + 1 - DT_W){1'b0}}, d};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  // Map pad buttons to UI buttons; the shoulders act as left or right when
  // exactly one of them is held and the combo is not.
  function automatic logic [UI_W-1:0] map_ui(input logic [BTN_W-1:0] b,
                                             input logic held);
    logic [UI_W-1:0] u;
    u = '0;
    u[UI_UP]     = b[BTN_UP];
    u[UI_DOWN]   = b[BTN_DOWN];
    u[UI_LEFT]   = b[BTN_LEFT];
    u[UI_RIGHT]  = b[BTN_RIGHT];
    u[UI_CIRCLE] = b[BTN_CIRCLE];
    if (!held && (b[BTN_L1] != b[BTN_R1])) begin
      if (b[BTN_L1]) begin
        u[UI_LEFT] = 1'b1;
      end else begin
        u[UI_RIGHT] = 1'b1;
      end
    end
    return u;
  endfunction

endpackage

`default_nettype wire

@@ design/cmt_cfg.sv @@
// Configuration register file: combo mask and hold time.
// Depends on cmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmt_cfg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [15:0]  cfg_data,
  output cmt_pkg::cfg_t     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.combo_mask   <= cmt_pkg::COMBO_MASK_RST;
      cfg.hold_time_ms <= cmt_pkg::HOLD_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cmt_pkg::cfg_reg_t'(cfg_index))
        cmt_pkg::CFG_COMBO_MASK: cfg.combo_mask   <= cfg_data;
        cmt_pkg::CFG_HOLD_TIME:  cfg.hold_time_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/cmt_core.sv @@
// Mode state registers and the single-pass update for one item.
// Depends on cmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmt_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire cmt_pkg::item_t  item,
  input  wire cmt_pkg::cfg_t   cfg,
  output cmt_pkg::result_t     res
);

  cmt_pkg::state_t st;
  cmt_pkg::state_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

  always_comb begin
    logic                           held;
    logic                           fired;
    logic [cmt_pkg::TIME_W-1:0]     ctime;
    logic [cmt_pkg::TIME_W-1:0]     xtime;
    logic [cmt_pkg::TIME_W-1:0]     hold_ext;
    cmt_pkg::state_t                s;
    cmt_pkg::ev_t                   ev;
    logic                           chg;

    s        = st;
    ev       = cmt_pkg::EV_NONE;
    chg      = 1'b0;
    fired    = 1'b0;
    held     = (item.buttons & cfg.combo_mask) == cfg.combo_mask;
    hold_ext = {1'b0, cfg.hold_time_ms};
    ctime    = cmt_pkg::add_sat(st.combo_seen ? st.combo_time : '0, item.elapsed_ms);
    xtime    = '0;

    case (item.cmd)
      cmt_pkg::CMD_FRAME: begin
        // Cross press tracking.
        if (!item.buttons[cmt_pkg::BTN_CROSS]) begin
          s.cross_pressed      = 1'b0;
          s.cross_counting     = 1'b0;
          s.cross_time         = '0;
          s.wait_cross_release = 1'b0;
        end else if (!st.cross_pressed) begin
          s.cross_pressed  = 1'b1;
          s.cross_counting = st.mode_on;
          s.cross_time     = '0;
        end
        xtime = cmt_pkg::add_sat(s.cross_time, item.elapsed_ms);

        // Combo hold toggle.
        if (!held) begin
          s.combo_seen  = 1'b0;
          s.combo_time  = '0;
          s.combo_fired = 1'b0;
        end else if (!st.combo_fired) begin
          s.combo_seen = 1'b1;
          s.combo_time = ctime;
          if (ctime >= hold_ext) begin
            fired            = 1'b1;
            s.combo_fired    = 1'b1;
            s.mode_on        = !st.mode_on;
            s.cross_counting = 1'b0;
            s.cross_time     = '0;
            ev = s.mode_on ? cmt_pkg::EV_ENTER : cmt_pkg::EV_EXIT;
          end
        end

        // Cross hold exit, skipped on the frame that toggled.
        if (!fired && s.mode_on && s.cross_counting) begin
          s.cross_time = xtime;
          if (xtime >= hold_ext) begin
            s.mode_on            = 1'b0;
            s.cross_counting     = 1'b0;
            s.wait_cross_release = 1'b1;
            ev                   = cmt_pkg::EV_EXIT;
          end
        end

        s.ui_latch = s.mode_on ? cmt_pkg::map_ui(item.buttons, held) : '0;
      end
      cmt_pkg::CMD_FORCE: begin
        if (st.mode_on != item.set_on) begin
          s.mode_on        = item.set_on;
          s.cross_counting = 1'b0;
          s.cross_time     = '0;
          if (!item.set_on) begin
            s.ui_latch = '0;
          end
          chg = 1'b1;
        end
      end
      default: ;
    endcase

    st_next         = s;
    res.ev          = ev;
    res.mode_active = s.mode_on;
    res.muted       = s.mode_on || s.wait_cross_release || held;
    res.ui_buttons  = s.ui_latch;
    res.changed     = chg;
  end

endmodule

`default_nettype wire

@@ design/combo_hold_mode_toggle.sv @@
// Top level of the gamepad combo hold mode toggle block.
// Depends on cmt_pkg, cmt_cfg and cmt_core.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The input channel takes one word per pad frame or force command (cmd,
// buttons, elapsed_ms, set_on) under in_valid / in_stall. The output channel
// returns exactly one result word per input word (event_res, mode_active,
// muted, ui_buttons, changed) under out_valid / out_stall, in order.
// A word accepted into the input register is processed by the single-pass
// update logic and lands in the result register, where its result waits to
// be taken. Throughput is one word per cycle while out_stall stays low; the
// input register and the result register together let a new word be taken
// while a finished result waits.
// When the receiver raises out_stall, the result register holds its word;
// the input register then fills and in_stall rises until the result is
// taken. The state registers advance only when a word moves from the input
// register into the result register, so a stall never loses or repeats an
// update.
// The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is
// always ready and should be used only while the block is idle.
// Synchronous reset empties both pipeline registers, clears all mode state and
// restores the combo mask to l1 plus r1 and the hold time to 1000 ms.

module combo_hold_mode_toggle (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [15:0] buttons,
  input  wire logic [9:0]  elapsed_ms,
  input  wire logic        set_on,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       event_res,
  output logic             mode_active,
  output logic             muted,
  output logic [4:0]       ui_buttons,
  output logic             changed,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  cmt_pkg::cfg_t    cfg;
  cmt_pkg::item_t   in_q;
  logic             in_full;
  cmt_pkg::result_t res;
  cmt_pkg::result_t res_q;
  logic             move;
  logic             step;

  // The result register can take a new word when it is empty or being read.
  assign move     = !(out_valid && out_stall);
  assign step     = in_full && move;
  assign in_stall = in_full && !move;

  cmt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q.cmd        <= cmt_pkg::cmd_t'(cmd);
      in_q.buttons    <= buttons;
      in_q.elapsed_ms <= elapsed_ms;
      in_q.set_on     <= set_on;
    end
  end

  cmt_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_q),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign event_res   = res_q.ev;
  assign mode_active = res_q.mode_active;
  assign muted       = res_q.muted;
  assign ui_buttons  = res_q.ui_buttons;
  assign changed     = res_q.changed;

endmodule

`default_nettype wire

@@ design/cmt_checker.sv @@
// Port-level checker for combo_hold_mode_toggle, with its bind statement.
// Depends on cmt_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module cmt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  event_res,
  input wire logic        mode_active,
  input wire logic        muted,
  input wire logic [4:0]  ui_buttons,
  input wire logic        changed
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(mode_active)
      && $stable(muted) && $stable(ui_buttons) && $stable(changed))
    else $error("result word changed while stalled");

  // A force command never reports an event.
  a_force_no_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && changed |-> event_res == cmt_pkg::EV_NONE)
    else $error("event reported on a force command");

  // UI buttons are blank with the mode off, and the active mode mutes the pad.
  a_ui_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mode_active ? muted : (ui_buttons == '0)))
    else $error("ui buttons or muting inconsistent with mode");

  // The event agrees with the reported mode.
  a_event_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((event_res == cmt_pkg::EV_NONE)
                || (event_res == cmt_pkg::EV_ENTER && mode_active)
                || (event_res == cmt_pkg::EV_EXIT && !mode_active)))
    else $error("event code inconsistent with mode");

endmodule

bind combo_hold_mode_toggle cmt_checker u_cmt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .event_res   (event_res),
  .mode_active (mode_active),
  .muted       (muted),
  .ui_buttons  (ui_buttons),
  .changed     (changed)
);

`default_nettype wire
